// ===== design/vln_pkg.sv =====
package vln_pkg;

  localparam int MAX_LENGTH = 64;
  localparam int ADDR_W     = $clog2(MAX_LENGTH);
  localparam int CNT_W      = $clog2(MAX_LENGTH + 1);
  localparam int DATA_W     = 16;
  localparam int SUM_W      = 37;
  localparam int FRAC_EXT   = 16;
  localparam int ARITH_W    = SUM_W + FRAC_EXT;
  localparam int ROOT_W     = (ARITH_W + 1) / 2;
  localparam int QUOT_W     = 16;
  localparam int STEP_W     = $clog2(QUOT_W);
  localparam int NUM_SHIFT  = 23;
  localparam int DIV_SHIFT  = QUOT_W - 1;
  localparam int SAT_SHIFT  = NUM_SHIFT - QUOT_W;

  // Outcome of one compare-and-subtract step
  typedef struct packed {
    logic               ge;
    logic [ARITH_W-1:0] diff;
  } sub_res_t;

  // Magnitude of a two's complement element; the most negative code maps to 2^15
  function automatic logic [DATA_W-1:0] magnitude(input logic [DATA_W-1:0] v);
    magnitude = v[DATA_W-1] ? (~v + DATA_W'(1)) : v;
  endfunction

endpackage

// ===== design/vln_store.sv =====
module vln_store (
  input  logic                       clk,
  input  logic                       we,
  input  logic [vln_pkg::ADDR_W-1:0] waddr,
  input  logic [vln_pkg::DATA_W-1:0] wdata,
  input  logic [vln_pkg::ADDR_W-1:0] raddr,
  output logic [vln_pkg::DATA_W-1:0] rdata
);
  import vln_pkg::*;

  logic [DATA_W-1:0] mem [MAX_LENGTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/vln_cmp_sub.sv =====
module vln_cmp_sub (
  input  logic [vln_pkg::ARITH_W-1:0] a,
  input  logic [vln_pkg::ARITH_W-1:0] b,
  output vln_pkg::sub_res_t           res
);
  import vln_pkg::*;

  logic [ARITH_W:0] wide;

  // Borrow out of the extended difference tells whether a < b
  assign wide     = {1'b0, a} - {1'b0, b};
  assign res.ge   = ~wide[ARITH_W];
  assign res.diff = wide[ARITH_W-1:0];

endmodule

// ===== design/vector_l2_normalizer.sv =====
// Channel   | Ports                                              | Handshake
// ----------+----------------------------------------------------+---------------------------
// element   | start, busy, element_value                         | taken on start && !busy
// result    | done, normalized_value, element_index,             | done pulse per result,
//           | last_of_vector                                     | no back-pressure
// config    | vector_length_we, vector_length                    | written on vector_length_we
//
// Each element request holds busy in ST_ACCUM while its square is added into
// the running sum, so the next element is taken only after that state.
// Completing a vector runs the restoring square root: 27 steps of the shared
// compare-subtract unit. Each element then passes through store read, setup,
// 16 quotient steps on the same unit and emit; a saturated or zero result skips the steps.
// Reset clears the sequencer, the sum, the count and sets the length to 64; the
// element store is not cleared, only entries written in the current vector are read.
// Results cannot be stalled: done marks each one for a single cycle.
module vector_l2_normalizer (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [vln_pkg::DATA_W-1:0] element_value,
  input  logic                              vector_length_we,
  input  logic        [vln_pkg::CNT_W-1:0]  vector_length,
  output logic                              done,
  output logic signed [vln_pkg::DATA_W-1:0] normalized_value,
  output logic        [vln_pkg::ADDR_W-1:0] element_index,
  output logic                              last_of_vector
);
  import vln_pkg::*;

  localparam logic [DATA_W-1:0] POS_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] NEG_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACCUM,
    ST_ROOT,
    ST_FETCH,
    ST_SETUP,
    ST_DIVIDE,
    ST_EMIT
  } state_t;

  state_t             state;
  logic [CNT_W-1:0]   length;
  logic [CNT_W-1:0]   count;
  logic [SUM_W-1:0]   sum;
  logic [DATA_W-1:0]  mag;
  logic [ARITH_W-1:0] rem;     // radicand during the root, remainder during division
  logic [ARITH_W-1:0] root;
  logic [ARITH_W-1:0] bit_pos;
  logic [ARITH_W-1:0] dvs;
  logic [QUOT_W-1:0]  quot;
  logic [STEP_W-1:0]  step;
  logic [ADDR_W-1:0]  k;
  logic               neg;
  logic               sat;
  logic               zero_norm;

  logic [CNT_W-1:0]   eff_len;
  logic [SUM_W-1:0]   sum_next;
  logic [2*DATA_W-1:0] square;
  logic               accept;
  logic [DATA_W-1:0]  rd_data;
  logic [DATA_W-1:0]  rd_mag;
  logic [ROOT_W-1:0]  norm;
  logic [ARITH_W-1:0] op_a;
  logic [ARITH_W-1:0] op_b;
  sub_res_t           unit_res;
  logic [DATA_W-1:0]  res_value;
  logic               is_last;

  assign accept   = start && !busy;
  assign busy     = (state != ST_IDLE);
  assign square   = mag * mag;
  assign sum_next = sum + SUM_W'(square);
  assign norm     = root[ROOT_W-1:0];
  assign rd_mag   = magnitude(rd_data);
  assign is_last  = (CNT_W'(k) + CNT_W'(1)) == count;

  // Clamp the programmed length into one to the store depth
  always_comb begin
    if (length == '0) begin
      eff_len = CNT_W'(1);
    end else if (length > CNT_W'(MAX_LENGTH)) begin
      eff_len = CNT_W'(MAX_LENGTH);
    end else begin
      eff_len = length;
    end
  end

  // Route the shared unit: radicand against trial root, or remainder against divisor
  always_comb begin
    case (state)
      ST_ROOT: begin
        op_a = rem;
        op_b = root | bit_pos;
      end
      ST_DIVIDE: begin
        op_a = rem;
        op_b = dvs;
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  // Apply sign and saturate the quotient into Q1.15
  always_comb begin
    if (zero_norm) begin
      res_value = '0;
    end else if (sat) begin
      res_value = neg ? NEG_MIN : POS_MAX;
    end else if (neg) begin
      res_value = (quot > NEG_MIN) ? NEG_MIN : (~quot + DATA_W'(1));
    end else begin
      res_value = quot[QUOT_W-1] ? POS_MAX : quot;
    end
  end

  vln_store u_store (
    .clk   (clk),
    .we    (accept),
    .waddr (count[ADDR_W-1:0]),
    .wdata (element_value),
    .raddr (k),
    .rdata (rd_data)
  );

  vln_cmp_sub u_unit (
    .a   (op_a),
    .b   (op_b),
    .res (unit_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      length <= CNT_W'(MAX_LENGTH);
      count  <= '0;
      sum    <= '0;
      k      <= '0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (vector_length_we) begin
        length <= vector_length;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            mag   <= magnitude(element_value);
            count <= count + CNT_W'(1);
            state <= ST_ACCUM;
          end
        end
        ST_ACCUM: begin
          sum <= sum_next;
          if (count >= eff_len) begin
            // Start the root on sum scaled by 2^16, top trial bit first
            rem     <= {sum_next, FRAC_EXT'(0)};
            root    <= '0;
            bit_pos <= {1'b1, {(ARITH_W-1){1'b0}}};
            k       <= '0;
            state   <= ST_ROOT;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_ROOT: begin
          if (unit_res.ge) begin
            rem  <= unit_res.diff;
            root <= (root >> 1) | bit_pos;
          end else begin
            root <= root >> 1;
          end
          bit_pos <= bit_pos >> 2;
          if (bit_pos[0]) begin
            state <= ST_FETCH;
          end
        end
        ST_FETCH: begin
          state <= ST_SETUP;
        end
        ST_SETUP: begin
          neg       <= rd_data[DATA_W-1];
          zero_norm <= (norm == '0);
          sat       <= (norm != '0) && ((ROOT_W'(rd_mag) << SAT_SHIFT) >= norm);
          rem       <= ARITH_W'(rd_mag) << NUM_SHIFT;
          dvs       <= ARITH_W'(norm) << DIV_SHIFT;
          quot      <= '0;
          step      <= '0;
          // Skip the quotient steps when the result is already settled
          if ((norm == '0) || ((ROOT_W'(rd_mag) << SAT_SHIFT) >= norm)) begin
            state <= ST_EMIT;
          end else begin
            state <= ST_DIVIDE;
          end
        end
        ST_DIVIDE: begin
          if (unit_res.ge) begin
            rem <= unit_res.diff;
          end
          quot <= {quot[QUOT_W-2:0], unit_res.ge};
          dvs  <= dvs >> 1;
          step <= step + STEP_W'(1);
          if (step == STEP_W'(QUOT_W - 1)) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          done             <= 1'b1;
          normalized_value <= res_value;
          element_index    <= k;
          last_of_vector   <= is_last;
          if (is_last) begin
            // Drop the sum and count so the next vector starts clean
            sum   <= '0;
            count <= '0;
            k     <= '0;
            state <= ST_IDLE;
          end else begin
            k     <= k + ADDR_W'(1);
            state <= ST_FETCH;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_accept_accum: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_ACCUM))
    else $error("accepted request did not move to accumulation");

  a_root_onehot: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ROOT) |-> $onehot(bit_pos))
    else $error("root trial bit is not one-hot");

  a_root_disjoint: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ROOT) |-> ((root & bit_pos) == '0))
    else $error("partial root overlaps the trial bit");

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    (done && last_of_vector) |-> ((count == '0) && (sum == '0) && !busy))
    else $error("vector end left state behind");

  a_mid_busy: assert property (@(posedge clk) disable iff (rst)
    (done && !last_of_vector) |-> busy)
    else $error("block went idle inside a vector");

endmodule

// ===== tb/vln_norm_checker.sv =====
`timescale 1ns / 1ps

module vln_norm_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic                              busy,
  input  logic signed [vln_pkg::DATA_W-1:0] element_value,
  input  logic                              vector_length_we,
  input  logic        [vln_pkg::CNT_W-1:0]  vector_length,
  input  logic                              done,
  input  logic signed [vln_pkg::DATA_W-1:0] normalized_value,
  input  logic        [vln_pkg::ADDR_W-1:0] element_index,
  input  logic                              last_of_vector,
  output int                                fail_count,
  output int                                pending,
  output int                                results_checked,
  output int                                vectors_done,
  output int                                requests_taken
);
  import vln_pkg::*;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic        [ADDR_W-1:0] index;
    logic                     last;
  } norm_result_t;

  norm_result_t      due_outputs[$];
  logic [DATA_W-1:0] elem_store[MAX_LENGTH];
  logic [SUM_W-1:0]  energy;
  int unsigned       loaded;
  logic [CNT_W-1:0]  len_reg;

  function automatic int unsigned eff_len(input logic [CNT_W-1:0] l);
    if (l == 0) return 1;
    if (l > MAX_LENGTH) return MAX_LENGTH;
    return 32'(l);
  endfunction

  // Bitwise restoring square root, floor
  function automatic logic [63:0] floor_sqrt(input logic [63:0] x);
    logic [63:0] rem;
    logic [63:0] root;
    logic [63:0] probe;
    rem   = x;
    root  = '0;
    probe = 64'h1 << 62;
    while (probe > rem) probe = probe >> 2;
    while (probe != 0) begin
      if (rem >= root + probe) begin
        rem  = rem - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    return root;
  endfunction

  // Element over norm in Q1.15, truncated toward zero and clamped
  function automatic logic [DATA_W-1:0] scale_to_unit(input logic [DATA_W-1:0] raw,
                                                       input logic [63:0] norm);
    logic [16:0] mag;
    logic [63:0] quot;
    mag  = raw[DATA_W-1] ? (17'h10000 - {1'b0, raw}) : {1'b0, raw};
    quot = '0;
    if (norm != 0) quot = ({47'b0, mag} << 23) / norm;
    if (raw[DATA_W-1]) begin
      if (quot > 64'd32768) quot = 64'd32768;
      return 16'd0 - quot[15:0];
    end
    if (quot > 64'd32767) quot = 64'd32767;
    return quot[15:0];
  endfunction

  task automatic load_element(input logic [DATA_W-1:0] raw);
    logic [16:0]  mag;
    logic [63:0]  norm;
    norm_result_t r;
    mag = raw[DATA_W-1] ? (17'h10000 - {1'b0, raw}) : {1'b0, raw};
    elem_store[ADDR_W'(loaded)] = raw;
    energy = energy + SUM_W'(mag) * SUM_W'(mag);
    loaded++;
    if (loaded >= eff_len(len_reg)) begin
      norm = (energy == 0) ? 64'd0 : floor_sqrt({11'b0, energy, 16'b0});
      for (int unsigned k = 0; k < loaded; k++) begin
        r.value = scale_to_unit(elem_store[ADDR_W'(k)], norm);
        r.index = ADDR_W'(k);
        r.last  = (k + 1 == loaded);
        due_outputs = {due_outputs, r};
      end
      vectors_done++;
      energy = '0;
      loaded = 0;
    end
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] mismatch on result %0d: %s got %0d, want %0d",
             $realtime, results_checked, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    norm_result_t want;
    if (rst) begin
      due_outputs.delete();
      energy  = '0;
      loaded  = 0;
      len_reg = CNT_W'(MAX_LENGTH);
    end else begin
      if (done) begin
        if (due_outputs.size() == 0) begin
          report_mismatch("unexpected result, value", int'(normalized_value), 0);
        end else begin
          want = due_outputs.pop_front();
          if (normalized_value !== want.value)
            report_mismatch("normalized_value", int'(normalized_value), int'(want.value));
          if (element_index !== want.index)
            report_mismatch("element_index", int'(element_index), int'(want.index));
          if (last_of_vector !== want.last)
            report_mismatch("last_of_vector", int'(last_of_vector), int'(want.last));
        end
        results_checked++;
      end
      if (start && !busy) begin
        load_element(element_value);
        requests_taken++;
      end
      if (vector_length_we) len_reg = vector_length;
    end
    pending = due_outputs.size();
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import vln_pkg::*;

  // Even if every request flushed a full vector of 64 results, a run would stay
  // well below this limit; allow far more
  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int RANDOM_ITEMS = 130;
  localparam int SETTLE       = 8;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     start = 1'b0;
  logic signed [DATA_W-1:0] element_value = '0;
  logic                     vector_length_we = 1'b0;
  logic        [CNT_W-1:0]  vector_length = '0;
  logic                     busy;
  logic                     done;
  logic signed [DATA_W-1:0] normalized_value;
  logic        [ADDR_W-1:0] element_index;
  logic                     last_of_vector;

  int fail_count;
  int pending;
  int results_checked;
  int vectors_done;
  int requests_taken;
  int cycle_count = 0;
  bit calm = 1'b0;

  always #5 clk = ~clk;

  vector_l2_normalizer dut (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .element_value    (element_value),
    .vector_length_we (vector_length_we),
    .vector_length    (vector_length),
    .done             (done),
    .normalized_value (normalized_value),
    .element_index    (element_index),
    .last_of_vector   (last_of_vector)
  );

  vln_norm_checker checker_i (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .element_value    (element_value),
    .vector_length_we (vector_length_we),
    .vector_length    (vector_length),
    .done             (done),
    .normalized_value (normalized_value),
    .element_index    (element_index),
    .last_of_vector   (last_of_vector),
    .fail_count       (fail_count),
    .pending          (pending),
    .results_checked  (results_checked),
    .vectors_done     (vectors_done),
    .requests_taken   (requests_taken)
  );

  // Watchdog: a hung block or a lost result ends the run here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Raise the request and hold it until the block takes it. On return we sit
  // on the accepting edge with start still high, so a following request can
  // reuse it without a drop; at random, unless calm is set, drop start and idle
  // with junk on the data lines.
  task automatic send_element(input logic [DATA_W-1:0] v);
    start         <= 1'b1;
    element_value <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (!calm && $urandom_range(0, 99) < 30) begin
      start         <= 1'b0;
      element_value <= DATA_W'($urandom);
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // Drop start and wait until every predicted result has come out, then give
  // the block time to finish the accumulation step of the last request.
  task automatic settle();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Length writes happen only on an idle block
  task automatic set_length(input logic [CNT_W-1:0] len);
    settle();
    vector_length_we <= 1'b1;
    vector_length    <= len;
    @(posedge clk);
    vector_length_we <= 1'b0;
    vector_length    <= CNT_W'($urandom);
  endtask

  // Wide random values half the time, with a share of extremes, zeros and tiny ones
  function automatic logic [DATA_W-1:0] pick_element();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 16'h8000;
      2:       return 16'h7fff;
      3:       return DATA_W'($urandom_range(0, 15));
      4:       return 16'd0 - DATA_W'($urandom_range(1, 16));
      default: return DATA_W'($urandom);
    endcase
  endfunction

  initial begin
    int unsigned     random_sent;
    int unsigned     eff;
    int unsigned     vecs;
    int unsigned     pick;
    bit              big_done;
    bit              zero_vec;
    logic [CNT_W-1:0] len;

    random_sent = 0;
    big_done    = 1'b0;

    // Hold reset, then release it once and for all
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Default length of 64: load three, then shrink the length below the count
    // already loaded, so the next request flushes all four as one vector.
    send_element(16'h7fff);
    send_element(16'h8000);
    send_element(16'h0000);
    set_length(CNT_W'(2));
    send_element(16'h0001);

    // Written zero acts as one: zero energy, most negative, saturation both ways
    set_length(CNT_W'(0));
    send_element(16'h0000);
    send_element(16'h8000);
    send_element(16'h7fff);
    send_element(16'h0001);
    send_element(16'hffff);

    // An all-zero vector, then zeros beside a single non-zero element
    set_length(CNT_W'(3));
    send_element(16'h0000);
    send_element(16'h0000);
    send_element(16'h0000);
    send_element(16'h0000);
    send_element(16'h0000);
    send_element(16'h0005);

    // Equal halves, opposite extremes, alternating bit patterns
    set_length(CNT_W'(2));
    send_element(16'h4000);
    send_element(16'h4000);
    send_element(16'h8000);
    send_element(16'h7fff);
    send_element(16'h5555);
    send_element(16'haaaa);

    // Write full length and leave two elements loaded for the first random phase
    set_length(CNT_W'(MAX_LENGTH));
    send_element(16'h1234);
    send_element(16'hfff9);

    // Random phases: new length, a few vectors, sometimes a trailing partial
    // vector that the next length change then has to deal with.
    while (random_sent < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (!big_done && (pick < 6 || random_sent > 70)) begin
        len      = $urandom_range(0, 1) ? CNT_W'(127) : CNT_W'(MAX_LENGTH);
        big_done = 1'b1;
      end else if (pick < 14) begin
        len = CNT_W'(0);
      end else if (pick < 30) begin
        len = CNT_W'($urandom_range(13, 24));
      end else begin
        len = CNT_W'($urandom_range(1, 12));
      end
      set_length(len);

      eff  = (len == 0) ? 1 : (len > MAX_LENGTH) ? MAX_LENGTH : len;
      vecs = (eff == MAX_LENGTH) ? 1 : $urandom_range(1, 3);
      for (int unsigned v = 0; v < vecs; v++) begin
        zero_vec = ($urandom_range(0, 9) == 0);
        for (int unsigned k = 0; k < eff; k++) begin
          // No idling at all in the middle stretch of the random part
          calm = (random_sent >= 50 && random_sent < 100);
          send_element(zero_vec ? '0 : pick_element());
          random_sent++;
        end
      end
      if (eff > 1 && $urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, eff - 1)) begin
          send_element(pick_element());
          random_sent++;
        end
      end
    end

    // Drain: every predicted result must arrive, then allow a short tail
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (40) @(posedge clk);

    $display("covered %0d element requests and %0d normalised vectors, %0d results compared",
             requests_taken, vectors_done, results_checked);
    $display("lengths 0, 1..24, 64 and above-range codes, with mid-vector length changes");
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== vector_l2_normalizer.f =====
design/vln_pkg.sv
design/vln_store.sv
design/vln_cmp_sub.sv
design/vector_l2_normalizer.sv
tb/vln_norm_checker.sv
tb/tb_top.sv
